/* design/ostev_pkg.sv */
// ----------------------------------------------------------------------------
// ostev_pkg
// Shared types, constants and helpers for the ocean spectrum time evolution
// pipeline.
// ----------------------------------------------------------------------------
package ostev_pkg;

  localparam int GRID_N = 64;
  localparam int GRID_M = 64;
  localparam int BIN_W  = 6;
  localparam int CB_W   = BIN_W + 1;
  localparam logic signed [CB_W-1:0] CENTRE_N = CB_W'(GRID_N / 2);
  localparam logic signed [CB_W-1:0] CENTRE_M = CB_W'(GRID_M / 2);

  localparam int STEP_W = 16;
  localparam int GRAV_W = 22;
  localparam int DATA_W = 32;
  localparam int K_W    = 22;
  localparam int RAD_W  = 44;
  localparam int ROOT_W = 22;
  localparam int REM_W  = 26;
  localparam int SQRT_STEPS  = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

  localparam int Q_W        = 32;
  localparam int DIV_R_W    = K_W + 1;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;

  localparam int CS_W          = 34;
  localparam int CORDIC_ITERS  = 24;
  localparam int CORDIC_STEPS  = 3;
  localparam int CORDIC_STAGES = CORDIC_ITERS / CORDIC_STEPS;
  localparam int CORDIC_GAIN   = 652032874;
  localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam int RECIP_W = 30;
  localparam logic [RECIP_W-1:0] TURN_RECIP = 30'd683565276;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd2;
  localparam logic [STEP_W-1:0] STEP_RESET    = 16'd412;
  localparam logic [GRAV_W-1:0] GRAVITY_RESET = 22'd642908;

  typedef struct packed {
    logic [31:0]        t;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    logic signed [K_W-1:0] kx;
    logic signed [K_W-1:0] kz;
    logic [ROOT_W-1:0]  kmag;
    logic signed [31:0] ux;
    logic signed [31:0] uz;
  } item_t;

  typedef struct packed {
    logic signed [31:0] height_re;
    logic signed [31:0] height_im;
    logic signed [31:0] slope_x_re;
    logic signed [31:0] slope_x_im;
    logic signed [31:0] slope_z_re;
    logic signed [31:0] slope_z_im;
    logic signed [31:0] disp_x_re;
    logic signed [31:0] disp_x_im;
    logic signed [31:0] disp_z_re;
    logic signed [31:0] disp_z_im;
  } result_t;

  function automatic logic signed [49:0] rnd16(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v + 66'sd32768;
    return s[65:16];
  endfunction

  function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v + 66'sd536870912;
    return s[65:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

/* design/ostev_if.sv */
// ----------------------------------------------------------------------------
// ostev interfaces
// Valid/ready channels for bins, evolved results and register writes.
// ----------------------------------------------------------------------------
interface ostev_bin_if;
  logic                     valid;
  logic                     ready;
  logic [5:0]               bin_n;
  logic [5:0]               bin_m;
  logic [31:0]              time_value;
  logic signed [31:0]       h0_re;
  logic signed [31:0]       h0_im;
  logic signed [31:0]       partner_re;
  logic signed [31:0]       partner_im;
  modport source (output valid, bin_n, bin_m, time_value, h0_re, h0_im, partner_re,
                  partner_im, input ready);
  modport sink (input valid, bin_n, bin_m, time_value, h0_re, h0_im, partner_re,
                partner_im, output ready);
endinterface

interface ostev_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] height_re;
  logic signed [31:0] height_im;
  logic signed [31:0] slope_x_re;
  logic signed [31:0] slope_x_im;
  logic signed [31:0] slope_z_re;
  logic signed [31:0] slope_z_im;
  logic signed [31:0] disp_x_re;
  logic signed [31:0] disp_x_im;
  logic signed [31:0] disp_z_re;
  logic signed [31:0] disp_z_im;
  modport source (output valid, height_re, height_im, slope_x_re, slope_x_im,
                  slope_z_re, slope_z_im, disp_x_re, disp_x_im, disp_z_re, disp_z_im,
                  input ready);
  modport sink (input valid, height_re, height_im, slope_x_re, slope_x_im,
                slope_z_re, slope_z_im, disp_x_re, disp_x_im, disp_z_re, disp_z_im,
                output ready);
endinterface

interface ostev_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [21:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/ostev_isqrt.sv */
// ----------------------------------------------------------------------------
// ostev_isqrt
// Pipelined floor square root, two result bits per stage.
// ----------------------------------------------------------------------------
module ostev_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ostev_pkg::RAD_W-1:0]  radicand,
  input  ostev_pkg::item_t             in_item,
  output logic                         out_valid,
  output logic [ostev_pkg::ROOT_W-1:0] root,
  output ostev_pkg::item_t             out_item
);
  localparam int ST = ostev_pkg::SQRT_STAGES;
  localparam int RW = ostev_pkg::RAD_W;
  localparam int MW = ostev_pkg::REM_W;
  localparam int OW = ostev_pkg::ROOT_W;

  logic [ST-1:0]    valid;
  logic [RW-1:0]    rad [ST];
  logic [MW-1:0]    rem [ST];
  logic [OW-1:0]    rt [ST];
  ostev_pkg::item_t itm [ST];
  logic [RW-1:0]    rad_next [ST];
  logic [MW-1:0]    rem_next [ST];
  logic [OW-1:0]    rt_next [ST];

  always_comb begin : step
    logic [RW-1:0] cr;
    logic [MW-1:0] cm;
    logic [MW-1:0] tm;
    logic [OW-1:0] co;
    logic [MW-1:0] trial;
    for (int s = 0; s < ST; s++) begin
      if (s == 0) begin
        cr = radicand;
        cm = '0;
        co = '0;
      end else begin
        cr = rad[s-1];
        cm = rem[s-1];
        co = rt[s-1];
      end
      for (int k = 0; k < ostev_pkg::SQRT_STEPS; k++) begin
        tm    = {cm[MW-3:0], cr[RW-1 -: 2]};
        cr    = cr << 2;
        trial = MW'({co, 2'b01});
        if (tm >= trial) begin
          cm = tm - trial;
          co = {co[OW-2:0], 1'b1};
        end else begin
          cm = tm;
          co = {co[OW-2:0], 1'b0};
        end
      end
      rad_next[s] = cr;
      rem_next[s] = cm;
      rt_next[s]  = co;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ST; s++) begin
        rad[s] <= rad_next[s];
        rem[s] <= rem_next[s];
        rt[s]  <= rt_next[s];
        if (s == 0) begin
          itm[s] <= in_item;
        end else begin
          itm[s] <= itm[s-1];
        end
      end
    end
  end

  assign out_valid = valid[ST-1];
  assign root      = rt[ST-1];
  assign out_item  = itm[ST-1];
endmodule

/* design/ostev_unit_div.sv */
// ----------------------------------------------------------------------------
// ostev_unit_div
// Pipelined restoring divider for the unit wave vector kx/|k|, kz/|k| (Q2.30).
// ----------------------------------------------------------------------------
module ostev_unit_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ostev_pkg::item_t in_item,
  output logic             out_valid,
  output ostev_pkg::item_t out_item
);
  localparam int ST = ostev_pkg::DIV_STAGES;
  localparam int RW = ostev_pkg::DIV_R_W;
  localparam int QW = ostev_pkg::Q_W;
  localparam int KW = ostev_pkg::K_W;

  logic [ST-1:0]    valid;
  logic [RW-1:0]    rr [ST][2];
  logic [QW-1:0]    qq [ST][2];
  logic [QW-1:0]    sh [ST][2];
  ostev_pkg::item_t itm [ST];
  logic [RW-1:0]    rr_next [ST][2];
  logic [QW-1:0]    qq_next [ST][2];
  logic [QW-1:0]    sh_next [ST][2];

  always_comb begin : step
    ostev_pkg::item_t src;
    logic signed [KW-1:0] kc;
    logic [KW-1:0] m;
    logic [RW-1:0] r;
    logic [RW-1:0] rs;
    logic [RW-1:0] d;
    logic [QW-1:0] q;
    logic [QW-1:0] st;
    for (int s = 0; s < ST; s++) begin
      if (s == 0) begin
        src = in_item;
      end else begin
        src = itm[s-1];
      end
      d = RW'(src.kmag);
      for (int l = 0; l < 2; l++) begin
        if (s == 0) begin
          kc = (l == 0) ? src.kx : src.kz;
          m  = kc[KW-1] ? KW'(-kc) : KW'(kc);
          r  = RW'(m >> 2);
          st = {m[1:0], {(QW-2){1'b0}}};
          q  = '0;
        end else begin
          r  = rr[s-1][l];
          st = sh[s-1][l];
          q  = qq[s-1][l];
        end
        for (int k = 0; k < ostev_pkg::DIV_STEPS; k++) begin
          rs = {r[RW-2:0], st[QW-1]};
          st = st << 1;
          if (rs >= d) begin
            r = rs - d;
            q = {q[QW-2:0], 1'b1};
          end else begin
            r = rs;
            q = {q[QW-2:0], 1'b0};
          end
        end
        rr_next[s][l] = r;
        qq_next[s][l] = q;
        sh_next[s][l] = st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ST; s++) begin
        rr[s] <= rr_next[s];
        qq[s] <= qq_next[s];
        sh[s] <= sh_next[s];
        if (s == 0) begin
          itm[s] <= in_item;
        end else begin
          itm[s] <= itm[s-1];
        end
      end
    end
  end

  // sign back on, zero wave vector gives zero
  always_comb begin
    out_item = itm[ST-1];
    if (itm[ST-1].kmag == '0) begin
      out_item.ux = '0;
      out_item.uz = '0;
    end else begin
      out_item.ux = itm[ST-1].kx[KW-1] ? -$signed(qq[ST-1][0]) : $signed(qq[ST-1][0]);
      out_item.uz = itm[ST-1].kz[KW-1] ? -$signed(qq[ST-1][1]) : $signed(qq[ST-1][1]);
    end
  end

  assign out_valid = valid[ST-1];
endmodule

/* design/ostev_cordic.sv */
// ----------------------------------------------------------------------------
// ostev_cordic
// Pipelined rotation CORDIC, Q0.32 turns in, Q2.30 cosine and sine out.
// ----------------------------------------------------------------------------
module ostev_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [31:0]                       turn,
  input  ostev_pkg::item_t                  in_item,
  output logic                              out_valid,
  output logic signed [ostev_pkg::CS_W-1:0] cosine,
  output logic signed [ostev_pkg::CS_W-1:0] sine,
  output ostev_pkg::item_t                  out_item
);
  localparam int ST = ostev_pkg::CORDIC_STAGES;
  localparam int W  = ostev_pkg::CS_W;
  localparam logic signed [W-1:0] QUARTER = W'(1) << 30;
  localparam logic signed [W-1:0] HALF    = W'(1) << 31;

  logic [ST-1:0]       valid;
  logic signed [W-1:0] xr [ST];
  logic signed [W-1:0] yr [ST];
  logic signed [W-1:0] ar [ST];
  logic [ST-1:0]       flip;
  ostev_pkg::item_t    itm [ST];
  logic signed [W-1:0] x_next [ST];
  logic signed [W-1:0] y_next [ST];
  logic signed [W-1:0] a_next [ST];
  logic [ST-1:0]       flip_next;

  always_comb begin : step
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] a;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic signed [W-1:0] at;
    logic f;
    for (int s = 0; s < ST; s++) begin
      if (s == 0) begin
        a = W'(signed'(turn));
        x = W'(ostev_pkg::CORDIC_GAIN);
        y = '0;
        f = 1'b0;
        // fold into the right half-plane
        if (a > QUARTER) begin
          a = a - HALF;
          f = 1'b1;
        end else if (a < -QUARTER) begin
          a = a + HALF;
          f = 1'b1;
        end
      end else begin
        x = xr[s-1];
        y = yr[s-1];
        a = ar[s-1];
        f = flip[s-1];
      end
      for (int k = 0; k < ostev_pkg::CORDIC_STEPS; k++) begin
        dx = y >>> (s * ostev_pkg::CORDIC_STEPS + k);
        dy = x >>> (s * ostev_pkg::CORDIC_STEPS + k);
        at = $signed(W'(ostev_pkg::ATAN_TURNS[s * ostev_pkg::CORDIC_STEPS + k]));
        if (a >= 0) begin
          x = x - dx;
          y = y + dy;
          a = a - at;
        end else begin
          x = x + dx;
          y = y - dy;
          a = a + at;
        end
      end
      x_next[s]    = x;
      y_next[s]    = y;
      a_next[s]    = a;
      flip_next[s] = f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[ST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flip <= flip_next;
      for (int s = 0; s < ST; s++) begin
        xr[s] <= x_next[s];
        yr[s] <= y_next[s];
        ar[s] <= a_next[s];
        if (s == 0) begin
          itm[s] <= in_item;
        end else begin
          itm[s] <= itm[s-1];
        end
      end
    end
  end

  assign out_valid = valid[ST-1];
  assign cosine    = flip[ST-1] ? -xr[ST-1] : xr[ST-1];
  assign sine      = flip[ST-1] ? -yr[ST-1] : yr[ST-1];
  assign out_item  = itm[ST-1];
endmodule

/* design/ostev_skid.sv */
// ----------------------------------------------------------------------------
// ostev_skid
// Output register with a skid slot; its ready is registered and stalls the pipe.
// ----------------------------------------------------------------------------
module ostev_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ostev_pkg::result_t in_data,
  output logic               in_ready,
  output logic               out_valid,
  output ostev_pkg::result_t out_data,
  input  logic               out_ready
);
  logic               skid_valid;
  ostev_pkg::result_t skid_data;
  logic               in_fire;
  logic               out_free;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= in_data;
      end
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end
endmodule

/* design/ocean_spectrum_time_evolution.sv */
// ----------------------------------------------------------------------------
// ocean_spectrum_time_evolution
// Evolves one ocean spectrum bin per item: height, slopes and displacements.
// ----------------------------------------------------------------------------
// Fully pipelined: one bin is accepted every clock cycle while the result side
// keeps up. On its way from acceptance to the output a bin passes through the
// chain of pipelined units: two square roots of 11 stages each, the
// unit-vector divider of 8 stages, the CORDIC of 8 stages and the multiply,
// round and saturate stages around them.
// A stall at the result side freezes the whole pipe after one extra result has
// been caught in the skid slot. Register writes take effect at once and are
// meant for when the pipe is empty.
module ocean_spectrum_time_evolution (
  input  logic       clk,
  input  logic       rst,
  ostev_bin_if.sink  spectrum,
  ostev_res_if.source evolved,
  ostev_cfg_if.sink  cfg
);
  localparam int KW = ostev_pkg::K_W;

  logic [ostev_pkg::STEP_W-1:0] step_x;
  logic [ostev_pkg::STEP_W-1:0] step_z;
  logic [ostev_pkg::GRAV_W-1:0] gravity;
  logic en;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_x  <= ostev_pkg::STEP_RESET;
      step_z  <= ostev_pkg::STEP_RESET;
      gravity <= ostev_pkg::GRAVITY_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ostev_pkg::REG_STEP_X:  step_x  <= cfg.data[ostev_pkg::STEP_W-1:0];
        ostev_pkg::REG_STEP_Z:  step_z  <= cfg.data[ostev_pkg::STEP_W-1:0];
        ostev_pkg::REG_GRAVITY: gravity <= cfg.data;
        default: ;
      endcase
    end
  end

  assign spectrum.ready = en;

  // wave vector
  logic signed [ostev_pkg::CB_W-1:0] cn, cm;
  logic signed [23:0] kx_prod, kz_prod;
  ostev_pkg::item_t a_item_next;
  always_comb begin
    cn = $signed({1'b0, spectrum.bin_n}) - ostev_pkg::CENTRE_N;
    cm = $signed({1'b0, spectrum.bin_m}) - ostev_pkg::CENTRE_M;
    kx_prod = cn * $signed({1'b0, step_x});
    kz_prod = cm * $signed({1'b0, step_z});
    a_item_next    = '0;
    a_item_next.t  = spectrum.time_value;
    a_item_next.ar = spectrum.h0_re;
    a_item_next.ai = spectrum.h0_im;
    a_item_next.br = spectrum.partner_re;
    a_item_next.bi = spectrum.partner_im;
    a_item_next.kx = kx_prod[KW-1:0];
    a_item_next.kz = kz_prod[KW-1:0];
  end

  logic a_valid, b_valid, c_valid, e_valid, f_valid, g_valid, h_valid;
  logic i_valid, j_valid, k_valid;
  ostev_pkg::item_t a_item, b_item, c_item, e_item, f_item, g_item, h_item;
  ostev_pkg::item_t i_item, j_item;
  logic signed [43:0] b_kx2, b_kz2;
  logic [43:0] c_ksum, e_gk;
  logic [53:0] f_p;
  logic [31:0] g_hi, h_turn;
  logic [29:0] g_lo;
  logic [51:0] hi_prod;
  logic [61:0] lo_prod;
  logic signed [65:0] i_arc, i_ais, i_brc, i_bis, i_ars, i_aic, i_bic, i_brs;
  logic signed [31:0] j_hr, j_hm;
  logic signed [65:0] k_xhm, k_xhr, k_zhm, k_zhr, k_uxm, k_uxr, k_uzm, k_uzr;

  logic sq1_valid, dv_valid, sq2_valid, cr_valid;
  logic [ostev_pkg::ROOT_W-1:0] sq1_root, sq2_root;
  ostev_pkg::item_t sq1_item, dv_in_item, dv_item, sq2_item, cr_item;
  logic signed [ostev_pkg::CS_W-1:0] cr_cos, cr_sin;

  always_comb begin
    dv_in_item      = sq1_item;
    dv_in_item.kmag = sq1_root;
    hi_prod = f_p[53:32] * ostev_pkg::TURN_RECIP;
    lo_prod = f_p[31:0] * ostev_pkg::TURN_RECIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
      h_valid <= 1'b0;
      i_valid <= 1'b0;
      j_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (en) begin
      a_valid <= spectrum.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      e_valid <= dv_valid;
      f_valid <= sq2_valid;
      g_valid <= f_valid;
      h_valid <= g_valid;
      i_valid <= cr_valid;
      j_valid <= i_valid;
      k_valid <= j_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= a_item_next;
      b_item <= a_item;
      b_kx2  <= a_item.kx * a_item.kx;
      b_kz2  <= a_item.kz * a_item.kz;
      c_item <= b_item;
      c_ksum <= $unsigned(b_kx2) + $unsigned(b_kz2);
      e_item <= dv_item;
      e_gk   <= gravity * dv_item.kmag;
      f_item <= sq2_item;
      f_p    <= sq2_root * sq2_item.t;
      g_item <= f_item;
      g_hi   <= hi_prod[31:0];
      g_lo   <= lo_prod[61:32];
      h_item <= g_item;
      h_turn <= g_hi + {2'b00, g_lo};
      i_item <= cr_item;
      i_arc  <= cr_item.ar * cr_cos;
      i_ais  <= cr_item.ai * cr_sin;
      i_brc  <= cr_item.br * cr_cos;
      i_bis  <= cr_item.bi * cr_sin;
      i_ars  <= cr_item.ar * cr_sin;
      i_aic  <= cr_item.ai * cr_cos;
      i_bic  <= cr_item.bi * cr_cos;
      i_brs  <= cr_item.br * cr_sin;
      j_item <= i_item;
      j_hr   <= ostev_pkg::sat32(ostev_pkg::rnd30(i_arc) - ostev_pkg::rnd30(i_ais)
                + ostev_pkg::rnd30(i_brc) + ostev_pkg::rnd30(i_bis));
      j_hm   <= ostev_pkg::sat32(ostev_pkg::rnd30(i_ars) + ostev_pkg::rnd30(i_aic)
                + ostev_pkg::rnd30(i_bic) - ostev_pkg::rnd30(i_brs));
      k_xhm  <= j_item.kx * j_hm;
      k_xhr  <= j_item.kx * j_hr;
      k_zhm  <= j_item.kz * j_hm;
      k_zhr  <= j_item.kz * j_hr;
      k_uxm  <= j_item.ux * j_hm;
      k_uxr  <= j_item.ux * j_hr;
      k_uzm  <= j_item.uz * j_hm;
      k_uzr  <= j_item.uz * j_hr;
    end
  end

  logic signed [31:0] k_hr, k_hm;
  always_ff @(posedge clk) begin
    if (en) begin
      k_hr <= j_hr;
      k_hm <= j_hm;
    end
  end

  ostev_isqrt u_kmag (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_valid), .radicand(c_ksum),
    .in_item(c_item), .out_valid(sq1_valid), .root(sq1_root), .out_item(sq1_item)
  );

  ostev_unit_div u_unit (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq1_valid), .in_item(dv_in_item),
    .out_valid(dv_valid), .out_item(dv_item)
  );

  ostev_isqrt u_omega (
    .clk(clk), .rst(rst), .en(en), .in_valid(e_valid), .radicand(e_gk),
    .in_item(e_item), .out_valid(sq2_valid), .root(sq2_root), .out_item(sq2_item)
  );

  ostev_cordic u_trig (
    .clk(clk), .rst(rst), .en(en), .in_valid(h_valid), .turn(h_turn),
    .in_item(h_item), .out_valid(cr_valid), .cosine(cr_cos), .sine(cr_sin),
    .out_item(cr_item)
  );

  // round, sign and saturate
  ostev_pkg::result_t res;
  always_comb begin
    res.height_re  = k_hr;
    res.height_im  = k_hm;
    res.slope_x_re = ostev_pkg::sat32(-ostev_pkg::rnd16(k_xhm));
    res.slope_x_im = ostev_pkg::sat32(ostev_pkg::rnd16(k_xhr));
    res.slope_z_re = ostev_pkg::sat32(-ostev_pkg::rnd16(k_zhm));
    res.slope_z_im = ostev_pkg::sat32(ostev_pkg::rnd16(k_zhr));
    res.disp_x_re  = ostev_pkg::sat32(ostev_pkg::rnd30(k_uxm));
    res.disp_x_im  = ostev_pkg::sat32(-ostev_pkg::rnd30(k_uxr));
    res.disp_z_re  = ostev_pkg::sat32(ostev_pkg::rnd30(k_uzm));
    res.disp_z_im  = ostev_pkg::sat32(-ostev_pkg::rnd30(k_uzr));
  end

  logic k_fire;
  logic out_valid;
  ostev_pkg::result_t out_data;
  assign k_fire = k_valid && en;

  ostev_skid u_skid (
    .clk(clk), .rst(rst), .in_valid(k_fire), .in_data(res), .in_ready(en),
    .out_valid(out_valid), .out_data(out_data), .out_ready(evolved.ready)
  );

  assign evolved.valid      = out_valid;
  assign evolved.height_re  = out_data.height_re;
  assign evolved.height_im  = out_data.height_im;
  assign evolved.slope_x_re = out_data.slope_x_re;
  assign evolved.slope_x_im = out_data.slope_x_im;
  assign evolved.slope_z_re = out_data.slope_z_re;
  assign evolved.slope_z_im = out_data.slope_z_im;
  assign evolved.disp_x_re  = out_data.disp_x_re;
  assign evolved.disp_x_im  = out_data.disp_x_im;
  assign evolved.disp_z_re  = out_data.disp_z_re;
  assign evolved.disp_z_im  = out_data.disp_z_im;

  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    !en |-> evolved.valid) else $error("pipe stalled with no result held");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    spectrum.valid && spectrum.ready |=> a_valid) else $error("accepted item lost");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(c_valid) && $stable(j_valid)) else $error("pipe moved during stall");
endmodule
